[sv/cplm_pkg.sv]
// Shared types and constants for the capture period lock meter.
// Used by cplm_ctrl, cplm_dp and capture_period_lock_meter; no dependencies.
package cplm_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic [DataW-1:0]  MinPeriodRst   = 32'd40000;
  localparam logic [DataW-1:0]  MaxPeriodRst   = 32'd80000;
  localparam logic [CountW-1:0] ThresholdRst   = 16'd5;
  localparam logic [DataW-1:0]  NumeratorRst   = 32'd80000000;
  localparam logic [DataW-1:0]  LockedRst      = 32'd100000;
  localparam logic [CountW-1:0] CountMax       = {CountW{1'b1}};

  typedef enum logic [1:0] {
    REG_MIN_PERIOD,
    REG_MAX_PERIOD,
    REG_MATCH_THRESHOLD,
    REG_FREQ_NUMERATOR
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILTER,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic filter;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

endpackage

[sv/cplm_ctrl.sv]
// Sequencer for the capture period lock meter: handshakes and step control.
// Depends on cplm_pkg; drives cplm_dp through cplm_pkg::cmd_t.
module cplm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cplm_pkg::cmd_t    cmd
);

  cplm_pkg::state_t               state, state_next;
  logic [cplm_pkg::StepW-1:0]     step, step_next;
  logic                           out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cplm_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      cplm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = cplm_pkg::ST_FILTER;
        end
      end
      cplm_pkg::ST_FILTER: begin
        cmd.filter    = 1'b1;
        cmd.div_start = 1'b1;
        step_next     = '0;
        state_next    = cplm_pkg::ST_DIVIDE;
      end
      cplm_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + cplm_pkg::StepW'(1);
        if (step == cplm_pkg::StepW'(cplm_pkg::DivSteps - 1)) begin
          state_next = cplm_pkg::ST_FINISH;
        end
      end
      cplm_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = cplm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cplm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/cplm_dp.sv]
// Datapath: period measurement, consistency filter, serial divider, result register.
// Depends on cplm_pkg; commanded by cplm_ctrl.
module cplm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cplm_pkg::cmd_t                cmd,
  input  logic [cplm_pkg::DataW-1:0]    capture_time,
  input  logic [cplm_pkg::DataW-1:0]    min_period,
  input  logic [cplm_pkg::DataW-1:0]    max_period,
  input  logic [cplm_pkg::CountW-1:0]   match_threshold,
  input  logic [cplm_pkg::DataW-1:0]    freq_numerator,
  output logic [cplm_pkg::DataW-1:0]    measured_period,
  output logic                          in_range,
  output logic [cplm_pkg::DataW-1:0]    accepted_period,
  output logic [cplm_pkg::DataW-1:0]    broadcast_freq
);

  logic [cplm_pkg::DataW-1:0]  previous_capture;
  logic [cplm_pkg::DataW-1:0]  candidate_period;
  logic [cplm_pkg::CountW-1:0] match_count;
  logic [cplm_pkg::DataW-1:0]  locked_period;
  logic [cplm_pkg::DataW-1:0]  period;
  logic                        period_ok;
  logic [cplm_pkg::DataW-1:0]  rem;
  logic [cplm_pkg::DataW-1:0]  quo;

  logic [cplm_pkg::DataW-1:0]  diff;
  logic [cplm_pkg::CountW-1:0] count_next;
  logic                        same;
  logic [cplm_pkg::DataW:0]    shifted;
  logic [cplm_pkg::DataW:0]    trial;
  logic                        fits;

  assign diff = capture_time - previous_capture;
  assign same = (period == candidate_period);

  always_comb begin
    if (!same) begin
      count_next = '0;
    end else if (match_count != cplm_pkg::CountMax) begin
      count_next = match_count + cplm_pkg::CountW'(1);
    end else begin
      count_next = match_count;
    end
  end

  // one restoring division step per cycle
  assign shifted = {rem, quo[cplm_pkg::DataW-1]};
  assign trial   = shifted - {1'b0, locked_period};
  assign fits    = (shifted >= {1'b0, locked_period});

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_capture <= '0;
      candidate_period <= '0;
      match_count      <= '0;
      locked_period    <= cplm_pkg::LockedRst;
    end else begin
      if (cmd.capture) begin
        previous_capture <= capture_time;
      end
      if (cmd.filter && period_ok) begin
        candidate_period <= period;
        match_count      <= count_next;
        if (count_next >= match_threshold) begin
          locked_period <= period;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      period    <= diff;
      period_ok <= (diff >= min_period) && (diff <= max_period);
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= freq_numerator;
    end else if (cmd.div_step) begin
      // for a nonzero divisor the partial remainder stays below it, so it fits the data width
      rem <= fits ? trial[cplm_pkg::DataW-1:0] : shifted[cplm_pkg::DataW-1:0];
      quo <= {quo[cplm_pkg::DataW-2:0], fits};
    end
    if (cmd.load_out) begin
      measured_period <= period;
      in_range        <= period_ok;
      accepted_period <= locked_period;
      // a zero divisor reports zero
      broadcast_freq  <= (locked_period == '0) ? '0 : quo;
    end
  end

endmodule

[sv/capture_period_lock_meter.sv]
// Top level of the capture period lock meter: register file and APB port.
// Depends on cplm_pkg, cplm_ctrl and cplm_dp.
//
// Each capture timestamp gives one result: the period since the previous
// capture (mod 2^32), an in-range flag, the locked period and
// freq_numerator / locked_period (floor, 0 for a zero period). The
// difference and range check are registered at the accepting edge, then
// the match filter runs, then the bit-serial restoring divider, and then
// the result is loaded into the output register, waiting while that
// register still holds an untransferred result. The next capture is taken
// only after that load. The block works on one capture at a time; a
// finished result waits in the output register while the next capture is
// already taken, and a second finished result holds the input until the
// first one is transferred. Registers at byte addresses 0x0 min_period,
// 0x4 max_period, 0x8 match_threshold, 0xC freq_numerator; change them
// only while the block is idle.
module capture_period_lock_meter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cplm_pkg::DataW-1:0]    capture_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cplm_pkg::DataW-1:0]    measured_period,
  output logic                          in_range,
  output logic [cplm_pkg::DataW-1:0]    accepted_period,
  output logic [cplm_pkg::DataW-1:0]    broadcast_freq,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cplm_pkg::AddrW-1:0]    paddr,
  input  logic [cplm_pkg::DataW-1:0]    pwdata,
  output logic [cplm_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [cplm_pkg::DataW-1:0]  min_period;
  logic [cplm_pkg::DataW-1:0]  max_period;
  logic [cplm_pkg::CountW-1:0] match_threshold;
  logic [cplm_pkg::DataW-1:0]  freq_numerator;
  cplm_pkg::reg_idx_t          reg_idx;
  logic                        wr_en;
  cplm_pkg::cmd_t              cmd;

  assign pready  = 1'b1;
  assign reg_idx = cplm_pkg::reg_idx_t'(paddr[cplm_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period      <= cplm_pkg::MinPeriodRst;
      max_period      <= cplm_pkg::MaxPeriodRst;
      match_threshold <= cplm_pkg::ThresholdRst;
      freq_numerator  <= cplm_pkg::NumeratorRst;
    end else if (wr_en) begin
      case (reg_idx)
        cplm_pkg::REG_MIN_PERIOD:      min_period      <= pwdata;
        cplm_pkg::REG_MAX_PERIOD:      max_period      <= pwdata;
        cplm_pkg::REG_MATCH_THRESHOLD: match_threshold <= pwdata[cplm_pkg::CountW-1:0];
        cplm_pkg::REG_FREQ_NUMERATOR:  freq_numerator  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cplm_pkg::REG_MIN_PERIOD:      prdata = min_period;
      cplm_pkg::REG_MAX_PERIOD:      prdata = max_period;
      cplm_pkg::REG_MATCH_THRESHOLD: prdata = cplm_pkg::DataW'(match_threshold);
      cplm_pkg::REG_FREQ_NUMERATOR:  prdata = freq_numerator;
      default:                       prdata = '0;
    endcase
  end

  cplm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cplm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .capture_time    (capture_time),
    .min_period      (min_period),
    .max_period      (max_period),
    .match_threshold (match_threshold),
    .freq_numerator  (freq_numerator),
    .measured_period (measured_period),
    .in_range        (in_range),
    .accepted_period (accepted_period),
    .broadcast_freq  (broadcast_freq)
  );

endmodule
